// ===== rtl/pds_pkg.sv =====
// ----------------------------------------------------------------------------
// PLL divider search package
// Shared constants, types and code tables of the PLL divider search block.
// ----------------------------------------------------------------------------
package pds_pkg;

  localparam int unsigned MAX_PRE_DIV  = 31;
  localparam int unsigned MAX_FB_MULT  = 127;
  localparam int unsigned MAX_POST_DIV = 512;

  localparam int unsigned PFD_MIN_KHZ   = 25000;
  localparam int unsigned PFD_MAX_KHZ   = 60000;
  localparam int unsigned VCO_MIN_KHZ   = 4800000;
  localparam int unsigned VCO_MAX_KHZ   = 14025000;
  localparam int unsigned VCO_BAND1_KHZ = 9000000;
  localparam int unsigned VCO_BAND2_KHZ = 12000000;
  localparam int unsigned HZ_PER_KHZ    = 1000;

  localparam int unsigned DIV_NUM_W = 39;
  localparam int unsigned DIV_DEN_W = 25;

  typedef enum logic [4:0] {
    ST_IDLE, ST_FREF, ST_FOUT, ST_NMIN, ST_NMAX, ST_MMIN, ST_MMAX,
    ST_MCHK, ST_MMUL, ST_LO, ST_HI, ST_NCHK, ST_VCO, ST_C0, ST_F,
    ST_DEN, ST_NUM, ST_ACH, ST_DONE
  } pds_state_e;

  typedef struct packed {
    logic        found;
    logic        exact;
    logic [4:0]  pre_divider;
    logic [6:0]  feedback_mult;
    logic [9:0]  post_divider;
    logic [23:0] vco_khz;
    logic [1:0]  loop_filter_code;
    logic [5:0]  charge_pump_code;
    logic [31:0] achieved_rate_hz;
  } pds_result_t;

  function automatic logic [1:0] lf_code(input logic [30:0] fvco, input logic [6:0] m);
    logic [1:0] code;
    if (fvco < 31'(VCO_BAND2_KHZ)) begin
      if (m <= 7'd15) code = 2'd2;
      else if (m <= 7'd31) code = 2'd0;
      else if (m <= 7'd71) code = 2'd1;
      else code = 2'd3;
    end else begin
      if (m <= 7'd23) code = 2'd0;
      else if (m <= 7'd55) code = 2'd1;
      else code = 2'd3;
    end
    return code;
  endfunction

  function automatic logic [5:0] cp_code(input logic [30:0] fvco, input logic [6:0] m);
    logic [5:0] code;
    if (fvco < 31'(VCO_BAND1_KHZ)) begin
      if (m <= 7'd15) code = 6'd29;
      else if (m <= 7'd23) code = 6'd28;
      else if (m <= 7'd31) code = 6'd29;
      else if (m <= 7'd47) code = 6'd28;
      else if (m <= 7'd55) code = 6'd29;
      else if (m <= 7'd71) code = 6'd36;
      else if (m <= 7'd103) code = 6'd29;
      else code = 6'd36;
    end else if (fvco < 31'(VCO_BAND2_KHZ)) begin
      if (m <= 7'd15) code = 6'd36;
      else if (m <= 7'd23) code = 6'd29;
      else if (m <= 7'd31) code = 6'd36;
      else if (m <= 7'd39) code = 6'd28;
      else if (m <= 7'd55) code = 6'd29;
      else if (m <= 7'd79) code = 6'd36;
      else if (m <= 7'd87) code = 6'd29;
      else code = 6'd36;
    end else begin
      if (m <= 7'd15) code = 6'd28;
      else if (m <= 7'd23) code = 6'd36;
      else if (m <= 7'd39) code = 6'd29;
      else if (m <= 7'd55) code = 6'd36;
      else if (m <= 7'd63) code = 6'd29;
      else code = 6'd36;
    end
    return code;
  endfunction

endpackage

// ===== rtl/pds_div.sv =====
// ----------------------------------------------------------------------------
// PLL divider search shared divider
// Restoring unsigned divider, one quotient bit per cycle, quotient held after done.
// ----------------------------------------------------------------------------
module pds_div #(
  parameter int unsigned NUM_W = pds_pkg::DIV_NUM_W,
  parameter int unsigned DEN_W = pds_pkg::DIV_DEN_W
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quo_o
);

  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic             busy_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [NUM_W-1:0] num_q;
  logic [DEN_W-1:0] den_q;
  logic [DEN_W-1:0] rem_q;
  logic [DEN_W:0]   rem_sh;
  logic             ge;

  assign rem_sh = {rem_q, num_q[NUM_W-1]};
  assign ge     = rem_sh >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(NUM_W - 1);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (busy_q) begin
      rem_q <= ge ? DEN_W'(rem_sh - {1'b0, den_q}) : rem_sh[DEN_W-1:0];
      num_q <= {num_q[NUM_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quo_o  = num_q;

endmodule

// ===== rtl/pds_seq.sv =====
// ----------------------------------------------------------------------------
// PLL divider search sequencer
// Walks the window bounds and the (m, n) candidates on the shared divider.
// ----------------------------------------------------------------------------
module pds_seq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [31:0]         ref_rate_hz_i,
  input  logic                start_i,
  input  logic [31:0]         target_rate_hz_i,
  output logic                idle_o,
  output logic                res_valid_o,
  input  logic                res_take_i,
  output pds_pkg::pds_result_t result_o
);
  import pds_pkg::*;

  localparam int unsigned NW = DIV_NUM_W;
  localparam int unsigned DW = DIV_DEN_W;

  pds_state_e state_q, state_d;

  logic          div_start, div_done;
  logic [NW-1:0] div_num, div_quo;
  logic [DW-1:0] div_den;
  logic          is_div_state;

  logic        issued_q;
  logic [31:0] tgt_q;
  logic [22:0] fref_q, fout_q;
  logic [6:0]  nmin_q, lo_q, n_q;
  logic [4:0]  nmax_q, hi_q;
  logic [28:0] m_q;
  logic [6:0]  mmax_q;
  logic [29:0] fm_q;
  logic [30:0] fvco_q;
  logic [9:0]  c0_q;
  logic        valid_q, exact_q;
  logic [4:0]  bn_q;
  logic [6:0]  bm_q;
  logic [9:0]  bc_q;
  logic [30:0] bv_q;
  logic [28:0] bf_q;
  logic [14:0] den_q;
  logic [38:0] num_q;
  logic [31:0] ach_q;

  logic [28:0] f_new, dist_new, dist_best, fout_x;
  logic        take, hit;
  logic [28:0] mmin_raw, mmin_clamp;

  pds_div #(.NUM_W(NW), .DEN_W(DW)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  assign f_new     = div_quo[28:0];
  assign fout_x    = 29'(fout_q);
  assign dist_new  = (f_new > fout_x) ? f_new - fout_x : fout_x - f_new;
  assign dist_best = (bf_q > fout_x) ? bf_q - fout_x : fout_x - bf_q;
  assign take      = !valid_q || (dist_new < dist_best);
  assign hit       = take && (f_new == fout_x);
  assign mmin_raw  = 29'(div_quo[21:0] * nmin_q);
  assign mmin_clamp = (mmin_raw < 29'd8) ? 29'd8 : mmin_raw;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (start_i) state_d = ST_FREF;
      ST_FREF: if (div_done) state_d = ST_FOUT;
      ST_FOUT: begin
        if (div_done) begin
          state_d = (div_quo == '0 || fref_q == '0) ? ST_DEN : ST_NMIN;
        end
      end
      ST_NMIN: if (div_done) state_d = ST_NMAX;
      ST_NMAX: if (div_done) state_d = ST_MMIN;
      ST_MMIN: if (div_done) state_d = ST_MMAX;
      ST_MMAX: if (div_done) state_d = ST_MCHK;
      ST_MCHK: state_d = (m_q > 29'(mmax_q)) ? ST_DEN : ST_MMUL;
      ST_MMUL: state_d = ST_LO;
      ST_LO:   if (div_done) state_d = ST_HI;
      ST_HI:   if (div_done) state_d = ST_NCHK;
      ST_NCHK: state_d = (n_q > 7'(hi_q)) ? ST_MCHK : ST_VCO;
      ST_VCO:  if (div_done) state_d = ST_C0;
      ST_C0:   if (div_done) state_d = ST_F;
      ST_F:    if (div_done) state_d = hit ? ST_DEN : ST_NCHK;
      ST_DEN:  state_d = valid_q ? ST_NUM : ST_DONE;
      ST_NUM:  state_d = ST_ACH;
      ST_ACH:  if (div_done) state_d = ST_DONE;
      ST_DONE: if (res_take_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    is_div_state = 1'b1;
    div_num      = '0;
    div_den      = DW'(1);
    unique case (state_q)
      ST_FREF: begin
        div_num = NW'(ref_rate_hz_i);
        div_den = DW'(HZ_PER_KHZ);
      end
      ST_FOUT: begin
        div_num = NW'(tgt_q);
        div_den = DW'(HZ_PER_KHZ);
      end
      ST_NMIN: begin
        div_num = NW'(fref_q) + NW'(PFD_MAX_KHZ - 1);
        div_den = DW'(PFD_MAX_KHZ);
      end
      ST_NMAX: begin
        div_num = NW'(fref_q);
        div_den = DW'(PFD_MIN_KHZ);
      end
      ST_MMIN: begin
        div_num = NW'(fref_q) + NW'(VCO_MIN_KHZ / 2 - 1);
        div_den = DW'(fref_q);
      end
      ST_MMAX: begin
        div_num = NW'(28'(VCO_MAX_KHZ / 2) * 28'(nmax_q));
        div_den = DW'(fref_q);
      end
      ST_LO: begin
        div_num = NW'(fm_q) + NW'(VCO_MAX_KHZ / 2 - 1);
        div_den = DW'(VCO_MAX_KHZ / 2);
      end
      ST_HI: begin
        div_num = NW'(fm_q);
        div_den = DW'(VCO_MIN_KHZ / 2);
      end
      ST_VCO: begin
        div_num = NW'({fm_q, 1'b0});
        div_den = DW'(n_q);
      end
      ST_C0: begin
        div_num = NW'(fvco_q) + NW'({fout_q, 1'b0});
        div_den = DW'({fout_q, 2'b00});
      end
      ST_F: begin
        div_num = NW'(fvco_q);
        div_den = DW'({c0_q, 2'b00});
      end
      ST_ACH: begin
        div_num = NW'(num_q);
        div_den = DW'(den_q);
      end
      default: is_div_state = 1'b0;
    endcase
    div_start   = is_div_state && !issued_q;
    idle_o      = (state_q == ST_IDLE);
    res_valid_o = (state_q == ST_DONE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      issued_q <= 1'b0;
      valid_q  <= 1'b0;
      exact_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (div_start) issued_q <= 1'b1;
      else if (div_done) issued_q <= 1'b0;
      if (state_q == ST_IDLE && start_i) begin
        valid_q <= 1'b0;
        exact_q <= 1'b0;
      end else if (state_q == ST_F && div_done && take) begin
        valid_q <= 1'b1;
        exact_q <= hit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: if (start_i) tgt_q <= target_rate_hz_i;
      ST_FREF: if (div_done) fref_q <= div_quo[22:0];
      ST_FOUT: if (div_done) fout_q <= div_quo[22:0];
      ST_NMIN: if (div_done) nmin_q <= (div_quo == '0) ? 7'd1 : div_quo[6:0];
      ST_NMAX: begin
        if (div_done) nmax_q <= (div_quo > NW'(MAX_PRE_DIV)) ? 5'(MAX_PRE_DIV) : div_quo[4:0];
      end
      ST_MMIN: if (div_done) m_q <= (mmin_clamp + 29'd1) & ~29'd1;
      ST_MMAX: begin
        if (div_done) mmax_q <= (div_quo > NW'(MAX_FB_MULT)) ? 7'(MAX_FB_MULT) : div_quo[6:0];
      end
      ST_MMUL: fm_q <= 30'(fref_q) * 30'(m_q[6:0]);
      ST_LO:   if (div_done) lo_q <= (div_quo[6:0] < nmin_q) ? nmin_q : div_quo[6:0];
      ST_HI: begin
        if (div_done) begin
          hi_q <= (div_quo > NW'(nmax_q)) ? nmax_q : div_quo[4:0];
          n_q  <= lo_q;
        end
      end
      ST_NCHK: if (n_q > 7'(hi_q)) m_q <= m_q + 29'd2;
      ST_VCO:  if (div_done) fvco_q <= div_quo[30:0];
      ST_C0: begin
        if (div_done) begin
          if (div_quo == '0) c0_q <= 10'd1;
          else if (div_quo > NW'(MAX_POST_DIV)) c0_q <= 10'(MAX_POST_DIV);
          else c0_q <= div_quo[9:0];
        end
      end
      ST_F: begin
        if (div_done) begin
          n_q <= n_q + 7'd1;
          if (take) begin
            bf_q <= f_new;
            bn_q <= n_q[4:0];
            bm_q <= m_q[6:0];
            bc_q <= c0_q;
            bv_q <= fvco_q;
          end
        end
      end
      ST_DEN:  den_q <= {14'(bc_q) * 14'(bn_q), 1'b0};
      ST_NUM:  num_q <= 39'(ref_rate_hz_i) * 39'(bm_q) + 39'(den_q[14:1]);
      ST_ACH: begin
        if (div_done) ach_q <= (div_quo > NW'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : div_quo[31:0];
      end
      default: ;
    endcase
  end

  always_comb begin
    result_o = '0;
    if (valid_q) begin
      result_o.found            = 1'b1;
      result_o.exact            = exact_q;
      result_o.pre_divider      = bn_q;
      result_o.feedback_mult    = bm_q;
      result_o.post_divider     = bc_q;
      result_o.vco_khz          = bv_q[23:0];
      result_o.loop_filter_code = lf_code(bv_q, bm_q);
      result_o.charge_pump_code = cp_code(bv_q, bm_q);
      result_o.achieved_rate_hz = ach_q;
    end
  end

endmodule

// ===== rtl/pll_divider_search_top.sv =====
// Divisions run one at a time on the shared divider; a search takes six setup
// divisions, two per feedback multiplier, three per candidate pair and one
// final division. The PFD and VCO windows allow at most about 600 pairs.
// Throughput: one word per search; input stalls until the result is loaded.
// The result register frees the sequencer unless it holds a stalled word.
// Reset is asynchronous, active low, and clears the reference rate to zero.
// ----------------------------------------------------------------------------
// PLL divider search top level
// Reference rate register, search sequencer and output result register.
// ----------------------------------------------------------------------------
module pll_divider_search_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] ref_rate_hz_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] target_rate_hz_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        found_o,
  output logic        exact_o,
  output logic [4:0]  pre_divider_o,
  output logic [6:0]  feedback_mult_o,
  output logic [9:0]  post_divider_o,
  output logic [23:0] vco_khz_o,
  output logic [1:0]  loop_filter_code_o,
  output logic [5:0]  charge_pump_code_o,
  output logic [31:0] achieved_rate_hz_o
);
  import pds_pkg::*;

  logic [31:0] ref_q;
  logic        seq_idle, res_valid, res_take;
  logic        out_valid_q, out_valid_d;
  pds_result_t seq_res, out_q;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = !seq_idle;
  assign res_take    = res_valid && (!out_valid_q || !out_stall_i);

  pds_seq u_seq (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .ref_rate_hz_i    (ref_q),
    .start_i          (in_valid_i && seq_idle),
    .target_rate_hz_i (target_rate_hz_i),
    .idle_o           (seq_idle),
    .res_valid_o      (res_valid),
    .res_take_i       (res_take),
    .result_o         (seq_res)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_take) out_valid_d = 1'b1;
    else if (!out_stall_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) ref_q <= ref_rate_hz_i;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take) out_q <= seq_res;
  end

  assign out_valid_o        = out_valid_q;
  assign found_o            = out_q.found;
  assign exact_o            = out_q.exact;
  assign pre_divider_o      = out_q.pre_divider;
  assign feedback_mult_o    = out_q.feedback_mult;
  assign post_divider_o     = out_q.post_divider;
  assign vco_khz_o          = out_q.vco_khz;
  assign loop_filter_code_o = out_q.loop_filter_code;
  assign charge_pump_code_o = out_q.charge_pump_code;
  assign achieved_rate_hz_o = out_q.achieved_rate_hz;

endmodule

// ===== rtl/pds_checker.sv =====
// ----------------------------------------------------------------------------
// PLL divider search port checker
// Checks result words seen on the top level ports.
// ----------------------------------------------------------------------------
module pds_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        found_o,
  input logic        exact_o,
  input logic [4:0]  pre_divider_o,
  input logic [6:0]  feedback_mult_o,
  input logic [9:0]  post_divider_o,
  input logic [23:0] vco_khz_o,
  input logic [31:0] achieved_rate_hz_o
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(achieved_rate_hz_o)
      && $stable(post_divider_o))
    else $error("stalled result word changed");

  a_exact_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && exact_o |-> found_o)
    else $error("exact result without a found divider set");

  a_not_found_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !found_o |-> pre_divider_o == 5'd0 && feedback_mult_o == 7'd0
      && post_divider_o == 10'd0 && vco_khz_o == 24'd0 && achieved_rate_hz_o == 32'd0)
    else $error("result fields not cleared when nothing was found");

  a_found_ranges: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && found_o |-> pre_divider_o != 5'd0 && feedback_mult_o >= 7'd8
      && !feedback_mult_o[0] && post_divider_o != 10'd0 && post_divider_o <= 10'd512)
    else $error("found divider set out of range");

endmodule

bind pll_divider_search_top pds_checker u_pds_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .out_valid_o        (out_valid_o),
  .out_stall_i        (out_stall_i),
  .found_o            (found_o),
  .exact_o            (exact_o),
  .pre_divider_o      (pre_divider_o),
  .feedback_mult_o    (feedback_mult_o),
  .post_divider_o     (post_divider_o),
  .vco_khz_o          (vco_khz_o),
  .achieved_rate_hz_o (achieved_rate_hz_o)
);
